### rtl/core/contiguous_block_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Contiguous block allocator assertion macros
// Shared assertion shorthands; every use samples on clk_i and is disabled
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define CBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cba_pkg.sv
// ----------------------------------------------------------------------------
// cba_pkg
// Sizes, codes and sequencer states of the contiguous block allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cba_pkg;

  localparam int BLOCKS    = 32;
  localparam int MAX_FILES = 16;

  localparam int MODE_W   = 2;
  localparam int NAME_W   = 24;
  localparam int BLK_W    = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // Cursor / sum width: holds start + count of two block fields.
  localparam int SUM_W  = BLK_W + 1;
  localparam int BLK_AW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int DIR_AW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int FC_W   = $clog2(MAX_FILES + 1);
  localparam int DIR_W  = NAME_W + 2 * BLK_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC    = 2'd0,
    MODE_RD_BLOCK = 2'd1,
    MODE_RD_DIR   = 2'd2,
    MODE_RSVD     = 2'd3
  } cba_mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_RANGE  = 3'd1,
    ST_BUSY   = 3'd2,
    ST_FULL   = 3'd3,
    ST_BADIDX = 3'd4
  } cba_status_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECODE = 3'd1,
    S_SCAN   = 3'd2,
    S_MARK   = 3'd3,
    S_RDBLK  = 3'd4,
    S_RDDIR  = 3'd5
  } cba_state_e;

endpackage

### rtl/core/cba_ram.sv
// ----------------------------------------------------------------------------
// cba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cba_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/contiguous_block_allocator_top.sv
// ----------------------------------------------------------------------------
// contiguous_block_allocator_top
// Contiguous block allocator: a block ownership map plus a file directory,
// served by a small sequencer around one shared adder and compare.
// ----------------------------------------------------------------------------
// Command channel: the word is taken at a rising edge with start_i high and
//   busy_o low; busy_o stays high until the result is out, and a second word
//   is only taken once busy_o drops, so start_i may stay high meanwhile.
// Result channel: done_o pulses for one cycle with status_o and the read
//   fields; the receiver cannot stall, so capture the word on that edge.
// Sequence: range errors, bad indexes, the unused mode and empty directory
//   slots finish in decode; block reads and directory hits add a registered
//   RAM read; an allocation runs a check pass, which stops with a busy
//   reject on the first used block or a full reject at the range end, then
//   a mark pass. The cursor adder and end compare step one block each cycle.
//   The next word may be taken at the edge that ends the done_o cycle.
// Reset clears the used map, the file count and the sequencer at once; the
//   owner and directory RAMs are not cleared; a block read of a free block
//   may read an unwritten owner entry, but its data is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "contiguous_block_allocator_top_macros.svh"

module contiguous_block_allocator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [cba_pkg::MODE_W-1:0]   mode_i,
  input  logic [cba_pkg::NAME_W-1:0]   file_name_i,
  input  logic [cba_pkg::BLK_W-1:0]    start_block_i,
  input  logic [cba_pkg::BLK_W-1:0]    block_count_i,
  input  logic [cba_pkg::BLK_W-1:0]    read_index_i,
  output logic                         done_o,
  output logic [cba_pkg::STATUS_W-1:0] status_o,
  output logic [cba_pkg::NAME_W-1:0]   owner_name_o,
  output logic                         owner_valid_o,
  output logic [cba_pkg::BLK_W-1:0]    entry_start_o,
  output logic [cba_pkg::BLK_W-1:0]    entry_length_o,
  output logic [cba_pkg::COUNT_W-1:0]  entry_count_o
);

  import cba_pkg::*;

  // Sequencer state
  cba_state_e state_q, state_d;

  // Latched request word
  cba_mode_e        mode_q;
  logic [NAME_W-1:0] name_q;
  logic [BLK_W-1:0]  start_q;
  logic [BLK_W-1:0]  count_q;
  logic [BLK_W-1:0]  idx_q;

  // Walk cursor and end of range
  logic [SUM_W-1:0] cursor_q, cursor_d;
  logic [SUM_W-1:0] end_q;
  logic [BLK_AW-1:0] cur_idx;

  // Persistent allocation state
  logic [BLOCKS-1:0] used_q;
  logic [FC_W-1:0]   file_count_q;
  logic [FC_W-1:0]   fc_next;

  // Result register
  logic              done_q;
  cba_status_e       res_status_q;
  logic [NAME_W-1:0] res_name_q;
  logic              res_valid_q;
  logic [BLK_W-1:0]  res_start_q;
  logic [BLK_W-1:0]  res_len_q;
  logic [COUNT_W-1:0] res_count_q;

  // Shared adder and compare
  logic [SUM_W-1:0] add_a, add_b, add_sum;
  logic             cmp_eq;

  // Decoded conditions
  logic range_bad, blk_idx_bad, dir_idx_bad, dir_hit, dir_full, blk_hit;

  // Sequencer controls
  logic        fin, rd_blk_fin, rd_dir_fin;
  cba_status_e fin_status;
  logic        end_ld, cur_ld_start, cur_inc;
  logic        used_set, own_we, own_re, dir_we, dir_re, fc_inc;

  // RAM read data
  logic [NAME_W-1:0] own_rdata;
  logic [DIR_W-1:0]  dir_rdata;

  // --------------------------------------------------------------------------
  // Shared arithmetic: range end in decode, cursor step while walking.
  // --------------------------------------------------------------------------
  always_comb begin
    if (state_q == S_DECODE) begin
      add_a = {1'b0, start_q};
      add_b = {1'b0, count_q};
    end else begin
      add_a = cursor_q;
      add_b = SUM_W'(1);
    end
  end

  assign add_sum = add_a + add_b;
  assign cmp_eq  = (cursor_q == end_q);
  assign cur_idx = cursor_q[BLK_AW-1:0];

  assign range_bad   = (add_sum > SUM_W'(BLOCKS));
  assign blk_idx_bad = ({1'b0, idx_q} >= SUM_W'(BLOCKS));
  assign dir_idx_bad = ({1'b0, idx_q} >= SUM_W'(MAX_FILES));
  assign dir_hit     = ({1'b0, idx_q} < SUM_W'(file_count_q));
  assign dir_full    = (file_count_q == FC_W'(MAX_FILES));
  assign blk_hit     = used_q[idx_q[BLK_AW-1:0]];
  assign fc_next     = file_count_q + FC_W'(fc_inc);

  // --------------------------------------------------------------------------
  // Sequencer outputs
  // --------------------------------------------------------------------------
  always_comb begin
    fin          = 1'b0;
    fin_status   = ST_OK;
    rd_blk_fin   = 1'b0;
    rd_dir_fin   = 1'b0;
    end_ld       = 1'b0;
    cur_ld_start = 1'b0;
    cur_inc      = 1'b0;
    used_set     = 1'b0;
    own_we       = 1'b0;
    own_re       = 1'b0;
    dir_we       = 1'b0;
    dir_re       = 1'b0;
    fc_inc       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
      end
      S_DECODE: begin
        unique case (mode_q)
          MODE_ALLOC: begin
            if (range_bad) begin
              fin        = 1'b1;
              fin_status = ST_RANGE;
            end else begin
              end_ld       = 1'b1;
              cur_ld_start = 1'b1;
            end
          end
          MODE_RD_BLOCK: begin
            if (blk_idx_bad) begin
              fin        = 1'b1;
              fin_status = ST_BADIDX;
            end else begin
              own_re = 1'b1;
            end
          end
          MODE_RD_DIR: begin
            if (dir_idx_bad) begin
              fin        = 1'b1;
              fin_status = ST_BADIDX;
            end else if (dir_hit) begin
              dir_re = 1'b1;
            end else begin
              fin = 1'b1;
            end
          end
          MODE_RSVD: begin
            fin        = 1'b1;
            fin_status = ST_BADIDX;
          end
        endcase
      end
      S_SCAN: begin
        // Check pass: stop on a used block, or at the end if full; else rewind.
        if (cmp_eq) begin
          if (dir_full) begin
            fin        = 1'b1;
            fin_status = ST_FULL;
          end else begin
            cur_ld_start = 1'b1;
          end
        end else if (used_q[cur_idx]) begin
          fin        = 1'b1;
          fin_status = ST_BUSY;
        end else begin
          cur_inc = 1'b1;
        end
      end
      S_MARK: begin
        // Mark pass: claim one block per cycle, then append the entry.
        if (cmp_eq) begin
          dir_we = 1'b1;
          fc_inc = 1'b1;
          fin    = 1'b1;
        end else begin
          own_we   = 1'b1;
          used_set = 1'b1;
          cur_inc  = 1'b1;
        end
      end
      S_RDBLK: begin
        fin        = 1'b1;
        rd_blk_fin = 1'b1;
      end
      S_RDDIR: begin
        fin        = 1'b1;
        rd_dir_fin = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (fin) begin
          state_d = S_IDLE;
        end else if (own_re) begin
          state_d = S_RDBLK;
        end else if (dir_re) begin
          state_d = S_RDDIR;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (fin) begin
          state_d = S_IDLE;
        end else if (cmp_eq) begin
          state_d = S_MARK;
        end
      end
      S_MARK: begin
        if (fin) begin
          state_d = S_IDLE;
        end
      end
      S_RDBLK, S_RDDIR: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cursor_d = cursor_q;
    if (cur_ld_start) begin
      cursor_d = {1'b0, start_q};
    end else if (cur_inc) begin
      cursor_d = add_sum;
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      used_q       <= '0;
      file_count_q <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      file_count_q <= fc_next;
      done_q       <= fin;
      if (used_set) begin
        used_q[cur_idx] <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      mode_q  <= cba_mode_e'(mode_i);
      name_q  <= file_name_i;
      start_q <= start_block_i;
      count_q <= block_count_i;
      idx_q   <= read_index_i;
    end
    if (end_ld) begin
      end_q <= add_sum;
    end
    cursor_q <= cursor_d;
    if (fin) begin
      res_status_q <= fin_status;
      res_count_q  <= COUNT_W'(fc_next);
      res_valid_q  <= (rd_blk_fin && blk_hit) || rd_dir_fin;
      if (rd_blk_fin && blk_hit) begin
        res_name_q <= own_rdata;
      end else if (rd_dir_fin) begin
        res_name_q <= dir_rdata[DIR_W-1 -: NAME_W];
      end else begin
        res_name_q <= '0;
      end
      if (rd_dir_fin) begin
        res_start_q <= dir_rdata[2*BLK_W-1 -: BLK_W];
        res_len_q   <= dir_rdata[BLK_W-1:0];
      end else begin
        res_start_q <= '0;
        res_len_q   <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Storage
  // --------------------------------------------------------------------------
  cba_ram #(
    .Width (NAME_W),
    .Depth (BLOCKS)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (cur_idx),
    .wdata_i (name_q),
    .re_i    (own_re),
    .raddr_i (idx_q[BLK_AW-1:0]),
    .rdata_o (own_rdata)
  );

  cba_ram #(
    .Width (DIR_W),
    .Depth (MAX_FILES)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (file_count_q[DIR_AW-1:0]),
    .wdata_i ({name_q, start_q, count_q}),
    .re_i    (dir_re),
    .raddr_i (idx_q[DIR_AW-1:0]),
    .rdata_o (dir_rdata)
  );

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign status_o       = res_status_q;
  assign owner_name_o   = res_name_q;
  assign owner_valid_o  = res_valid_q;
  assign entry_start_o  = res_start_q;
  assign entry_length_o = res_len_q;
  assign entry_count_o  = res_count_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CBA_ASSERT_NXT(a_accept_busy, start_i && !busy_o, busy_o, "accepted word did not raise busy")
  `CBA_ASSERT_NXT(a_done_after_busy, busy_o && !fin, !done_o, "result strobe without finish")
  `CBA_ASSERT_IMP(a_mark_free, (state_q == S_MARK) && !cmp_eq, !used_q[cur_idx], "marking a used block")
  `CBA_ASSERT_IMP(a_count_step, file_count_q != $past(file_count_q), done_q && (res_status_q == ST_OK), "file count moved without an ok allocation")

endmodule
